// ===== rtl/spi_pkg.sv =====
package spi_pkg;

  // Fixed widths of the stream fields and the stored samples
  localparam int SAMPLE_BITS   = 16;
  localparam int NOTE_W        = 7;
  localparam int VEL_W         = 7;
  localparam int ADDR_W        = 16;
  localparam int LEN_W         = 17;
  localparam int RATE_W        = 18;
  localparam int MODE_W        = 3;
  localparam int IN_DATA_W     = 48;

  // 440 Hz times the semitone ratio in 16-bit fixed point fits in 26 bits
  localparam int SEMI_PROD_W   = 26;

  // Division by 127 through a reciprocal: floor(n / 127) = (n * K) >> 30
  // holds for every n below 2^23.
  localparam int              RECIP_W     = 24;
  localparam int              RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_K  = 24'd8454661;

  // Configuration register indexes (byte address bit 2)
  localparam logic CFG_IDX_LENGTH = 1'b0;
  localparam logic CFG_IDX_RATE   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_NOTE_ON  = 3'd1,
    MODE_NOTE_OFF = 3'd2,
    MODE_END      = 3'd3,
    MODE_LOAD     = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTE_SETUP,
    S_DIVIDE,
    S_NOTE_DONE,
    S_CHECK,
    S_READ_HI,
    S_MULTIPLY,
    S_INTERP,
    S_GAIN,
    S_RECIP,
    S_EMIT,
    S_SILENT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic table_write;
    logic voice_off;
    logic note_setup;
    logic div_step;
    logic note_done;
    logic read_lo;
    logic read_hi;
    logic multiply;
    logic interp;
    logic gain;
    logic recip;
    logic emit_sample;
    logic emit_silent;
  } spi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mode_t mode;
    logic  voice_active;
    logic  at_end;
    logic  div_last;
    logic  out_free;
  } spi_stat_t;

  // 440 * round(2^(k/12) * 2^16) for semitone k of the octave
  function automatic logic [SEMI_PROD_W-1:0] semi_prod(input logic [3:0] k);
    logic [SEMI_PROD_W-1:0] p;
    unique case (k)
      4'd0:    p = 26'd28835840;
      4'd1:    p = 26'd30550520;
      4'd2:    p = 26'd32367280;
      4'd3:    p = 26'd34291840;
      4'd4:    p = 26'd36330800;
      4'd5:    p = 26'd38491200;
      4'd6:    p = 26'd40780080;
      4'd7:    p = 26'd43204920;
      4'd8:    p = 26'd45774080;
      4'd9:    p = 26'd48495920;
      4'd10:   p = 26'd51379680;
      4'd11:   p = 26'd54434600;
      default: p = 26'd28835840;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/spi_ctrl.sv =====
module spi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  spi_pkg::spi_stat_t stat,
  output spi_pkg::spi_cmd_t  cmd
);
  import spi_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (stat.mode)
            MODE_TICK:    state_nxt = S_CHECK;
            MODE_NOTE_ON: state_nxt = S_NOTE_SETUP;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_NOTE_SETUP: state_nxt = S_DIVIDE;
      S_DIVIDE: begin
        if (stat.div_last) begin
          state_nxt = S_NOTE_DONE;
        end
      end
      S_NOTE_DONE: state_nxt = S_IDLE;
      S_CHECK: begin
        if (!stat.voice_active || stat.at_end) begin
          state_nxt = S_SILENT;
        end else begin
          state_nxt = S_READ_HI;
        end
      end
      S_READ_HI:  state_nxt = S_MULTIPLY;
      S_MULTIPLY: state_nxt = S_INTERP;
      S_INTERP:   state_nxt = S_GAIN;
      S_GAIN:     state_nxt = S_RECIP;
      S_RECIP:    state_nxt = S_EMIT;
      S_EMIT, S_SILENT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.accept      = in_tvalid;
        cmd.table_write = in_tvalid && (stat.mode == MODE_LOAD);
        cmd.voice_off   = in_tvalid && (stat.mode == MODE_END);
      end
      S_NOTE_SETUP: cmd.note_setup = 1'b1;
      S_DIVIDE:     cmd.div_step   = 1'b1;
      S_NOTE_DONE:  cmd.note_done  = 1'b1;
      S_CHECK: begin
        // Running off the end of the table silences the voice until the next note-on
        cmd.voice_off = stat.at_end;
        cmd.read_lo   = stat.voice_active && !stat.at_end;
      end
      S_READ_HI:  cmd.read_hi     = 1'b1;
      S_MULTIPLY: cmd.multiply    = 1'b1;
      S_INTERP:   cmd.interp      = 1'b1;
      S_GAIN:     cmd.gain        = 1'b1;
      S_RECIP:    cmd.recip       = 1'b1;
      S_EMIT:     cmd.emit_sample = stat.out_free;
      S_SILENT:   cmd.emit_silent = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== rtl/spi_datapath.sv =====
module spi_datapath #(
  parameter int TABLE_DEPTH     = 65536,
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  spi_pkg::spi_cmd_t                       cmd,
  output spi_pkg::spi_stat_t                      stat,
  input  logic [spi_pkg::MODE_W-1:0]              in_mode,
  input  logic [spi_pkg::NOTE_W-1:0]              note_number,
  input  logic [spi_pkg::VEL_W-1:0]               velocity,
  input  logic [spi_pkg::ADDR_W-1:0]              table_address,
  input  logic signed [spi_pkg::SAMPLE_BITS-1:0]  table_value,
  input  logic [spi_pkg::LEN_W-1:0]               sample_length,
  input  logic [spi_pkg::RATE_W-1:0]              recording_rate,
  input  logic                                    out_tready,
  output logic                                    out_tvalid,
  output logic [spi_pkg::SAMPLE_BITS-1:0]         out_sample,
  output logic                                    out_playing
);
  import spi_pkg::*;

  localparam int PFB      = PHASE_FRAC_BITS;
  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int PW       = AW + PFB;
  localparam int STEP_W   = 8 + PFB;
  localparam int SUM_W    = ((PW > STEP_W) ? PW : STEP_W) + 1;
  localparam int EMAX     = PFB - 12;
  localparam int EMIN     = PFB - 22;
  localparam int EPOS     = (EMAX > 0) ? EMAX : 0;
  localparam int ENEG     = (EMIN < 0) ? -EMIN : 0;
  localparam int DEN_W    = RATE_W + ENEG;
  localparam int NUM_W    = (((SEMI_PROD_W + EPOS) > DEN_W) ? (SEMI_PROD_W + EPOS) : DEN_W) + 1;
  localparam int QW       = (NUM_W > STEP_W) ? NUM_W : STEP_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int LCW      = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int ACW      = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int SB       = SAMPLE_BITS;
  localparam int DIFF_W   = SB + 1;
  localparam int MUL_W    = DIFF_W + PFB + 1;
  localparam int IW       = SB + 1;
  localparam int YW       = IW + 8;
  localparam int RW       = SB + 7;
  localparam int RP_W     = RW + RECIP_W;

  localparam logic [LCW-1:0]          DEPTH_L    = LCW'(TABLE_DEPTH);
  localparam logic [ACW-1:0]          DEPTH_A    = ACW'(TABLE_DEPTH);
  localparam logic [PW:0]             PHASE_SAT  = ((PW + 1)'(TABLE_DEPTH) << PFB) - 1'b1;
  localparam logic [QW-1:0]           STEP_LIM   = QW'({STEP_W{1'b1}});
  localparam logic [STEP_W-1:0]       STEP_ONE   = STEP_W'(1) << PFB;
  localparam logic signed [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (PFB - 1);

  // Voice state
  logic [PW-1:0]     phase_r;
  logic [STEP_W-1:0] step_r;
  logic [VEL_W-1:0]  gain_r;
  logic              active_r;

  // Captured note-on fields
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;

  // Divider
  logic [NUM_W-1:0]  div_num_r;
  logic [DEN_W-1:0]  div_den_r;
  logic [DEN_W-1:0]  div_rem_r;
  logic [CNT_W-1:0]  div_cnt_r;

  // Sample path
  logic signed [SB-1:0]    table_mem [TABLE_DEPTH];
  logic signed [SB-1:0]    rdata_r;
  logic signed [SB-1:0]    s0_r;
  logic signed [MUL_W-1:0] mul_r;
  logic signed [IW-1:0]    interp_r;
  logic signed [YW-1:0]    y_r;
  logic                    neg_r;
  logic [RP_W-1:0]         rprod_r;

  // Output register
  logic              out_valid_r;
  logic [SB-1:0]     out_data_r;
  logic              out_play_r;

  // Note-on arithmetic
  logic [7:0]              note_d;
  logic [15:0]             oct_prod;
  logic [3:0]              octave;
  logic [7:0]              semi_w;
  logic signed [7:0]       expo;
  logic signed [7:0]       neg_expo;
  logic [5:0]              num_sh;
  logic [5:0]              den_sh;
  logic [RATE_W-1:0]       rate_eff;
  logic [NUM_W-1:0]        num_full;
  logic [DEN_W-1:0]        den_full;
  logic [NUM_W-1:0]        num_round;
  logic [DEN_W:0]          div_trial;
  logic                    div_ge;
  logic [DEN_W-1:0]        rem_nxt;

  // Tick arithmetic
  logic [AW-1:0]           idx;
  logic [PFB-1:0]          frac;
  logic [LCW-1:0]          len_eff;
  logic [AW-1:0]           raddr;
  logic                    addr_ok;
  logic [AW-1:0]           waddr;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PFB:0]     frac_s;
  logic signed [MUL_W-1:0] mul_nxt;
  logic signed [MUL_W-1:0] mul_rnd;
  logic signed [MUL_W-1:0] mul_sh;
  logic signed [IW-1:0]    interp_nxt;
  logic signed [7:0]       gain_s;
  logic signed [YW-1:0]    y_nxt;
  logic [YW-1:0]           y_mag;
  logic [RW-1:0]           recip_n;
  logic [SB-1:0]           quot;
  logic [SB-1:0]           sample_nxt;
  logic [SUM_W-1:0]        phase_sum;
  logic [PW-1:0]           phase_nxt;
  logic [STEP_W-1:0]       step_nxt;

  // Octave and semitone of note + 3; d * 171 >> 11 equals d / 12 for d up to 130
  always_comb begin
    note_d    = 8'(note_r) + 8'd3;
    oct_prod  = 16'(note_d) * 16'd171;
    octave    = oct_prod[14:11];
    semi_w    = note_d - 8'(octave) * 8'd12;
    expo      = $signed(8'(octave)) + 8'(PFB - 22);
    neg_expo  = -expo;
    num_sh    = expo[7] ? 6'd0 : expo[5:0];
    den_sh    = expo[7] ? neg_expo[5:0] : 6'd0;
    rate_eff  = (recording_rate == '0) ? RATE_W'(1) : recording_rate;
    num_full  = NUM_W'(semi_prod(semi_w[3:0])) << num_sh;
    den_full  = DEN_W'(rate_eff) << den_sh;
    num_round = num_full + NUM_W'(den_full >> 1);
  end

  // One restoring division step: quotient bits shift into the numerator register
  always_comb begin
    div_trial = {div_rem_r, div_num_r[NUM_W-1]};
    div_ge    = div_trial >= {1'b0, div_den_r};
    rem_nxt   = div_ge ? DEN_W'(div_trial - {1'b0, div_den_r}) : DEN_W'(div_trial);
    step_nxt  = (QW'(div_num_r) > STEP_LIM) ? {STEP_W{1'b1}} : STEP_W'(div_num_r);
  end

  // Table addressing and end-of-table test
  always_comb begin
    idx     = phase_r[PW-1:PFB];
    frac    = phase_r[PFB-1:0];
    len_eff = (LCW'(sample_length) > DEPTH_L) ? DEPTH_L : LCW'(sample_length);
    raddr   = cmd.read_hi ? (idx + AW'(1)) : idx;
    addr_ok = ACW'(table_address) < DEPTH_A;
    waddr   = AW'(table_address);
  end

  // Interpolation, gain and reciprocal scaling
  always_comb begin
    diff       = DIFF_W'(rdata_r) - DIFF_W'(s0_r);
    frac_s     = {1'b0, frac};
    mul_nxt    = diff * frac_s;
    mul_rnd    = mul_r + ROUND_HALF;
    mul_sh     = mul_rnd >>> PFB;
    interp_nxt = IW'(mul_sh) + IW'(s0_r);
    gain_s     = {1'b0, gain_r};
    y_nxt      = interp_r * gain_s;
    y_mag      = y_r[YW-1] ? YW'(-y_r) : YW'(y_r);
    recip_n    = RW'(y_mag) + RW'(7'd63);
    quot       = rprod_r[RECIP_SHIFT +: SB];
    sample_nxt = neg_r ? SB'(-quot) : quot;
  end

  // Phase advance with saturation at the table end
  always_comb begin
    phase_sum = SUM_W'(phase_r) + SUM_W'(step_r);
    phase_nxt = (phase_sum > SUM_W'(PHASE_SAT)) ? PW'(PHASE_SAT) : PW'(phase_sum);
  end

  // Sample table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.table_write && addr_ok) begin
      table_mem[waddr] <= table_value;
    end
    if (cmd.read_lo || cmd.read_hi) begin
      rdata_r <= table_mem[raddr];
    end
  end

  // Voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      step_r   <= STEP_ONE;
      gain_r   <= '1;
      active_r <= 1'b0;
    end else begin
      if (cmd.note_done) begin
        phase_r  <= '0;
        step_r   <= step_nxt;
        gain_r   <= vel_r;
        active_r <= 1'b1;
      end else if (cmd.voice_off) begin
        active_r <= 1'b0;
      end
      if (cmd.emit_sample) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Note capture and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      note_r <= note_number;
      vel_r  <= velocity;
    end
    if (cmd.note_setup) begin
      div_num_r <= num_round;
      div_den_r <= den_full;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_num_r <= {div_num_r[NUM_W-2:0], div_ge};
      div_rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
  end

  // Sample pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.read_hi) begin
      s0_r <= rdata_r;
    end
    if (cmd.multiply) begin
      mul_r <= mul_nxt;
    end
    if (cmd.interp) begin
      interp_r <= interp_nxt;
    end
    if (cmd.gain) begin
      y_r <= y_nxt;
    end
    if (cmd.recip) begin
      neg_r   <= y_r[YW-1];
      rprod_r <= RP_W'(recip_n) * RP_W'(RECIP_K);
    end
  end

  // Output register: the next item may be taken while a result waits here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_silent) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample) begin
      out_data_r <= sample_nxt;
      out_play_r <= 1'b1;
    end else if (cmd.emit_silent) begin
      out_data_r <= '0;
      out_play_r <= 1'b0;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_sample  = out_data_r;
  assign out_playing = out_play_r;

  // Status to the controller
  always_comb begin
    stat.mode         = mode_t'(in_mode);
    stat.voice_active = active_r;
    stat.at_end       = (LCW'(idx) + LCW'(1)) >= len_eff;
    stat.div_last     = div_cnt_r == CNT_W'(NUM_W - 1);
    stat.out_free     = !out_valid_r || out_tready;
  end

endmodule

// ===== rtl/sample_playback_interpolator.sv =====
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tuser: mode; tdata: note, velocity, address, value
// out_      master     out_tvalid/out_tready tdata: audio_sample; tuser: playing
// cfg_      APB slave  psel/penable/pready  0x0 sample_length, 0x4 recording_rate
//
// Items are handled one at a time. A tick runs the check, high read, multiply,
// interpolate, gain, reciprocal and emit states, set by the two single-port table reads
// and the multiply chain; a silent tick runs check and silent emit. A note-on runs setup,
// the one-bit-per-cycle step divider and done. Load, end and note-off complete on acceptance.
// Reset is synchronous and needs no clearing pass; the table is undefined until
// loaded. A stalled result sits in the output register while the next item is taken.
module sample_playback_interpolator #(
  parameter int TABLE_DEPTH     = 65536,
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: note_number[6:0], velocity[13:7], table_address[29:14],
  //        table_value[45:30], zero[47:46]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: audio_sample[15:0]
  output logic [15:0] out_tdata,
  // tuser: playing[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import spi_pkg::*;

  logic [LEN_W-1:0]  sample_length_r;
  logic [RATE_W-1:0] recording_rate_r;
  logic              cfg_write;
  spi_cmd_t          cmd;
  spi_stat_t         stat;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_length_r  <= '0;
      recording_rate_r <= RATE_W'(48000);
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        CFG_IDX_LENGTH: sample_length_r  <= cfg_pwdata[LEN_W-1:0];
        CFG_IDX_RATE:   recording_rate_r <= cfg_pwdata[RATE_W-1:0];
        default:        sample_length_r  <= sample_length_r;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_LENGTH: cfg_prdata = 32'(sample_length_r);
      CFG_IDX_RATE:   cfg_prdata = 32'(recording_rate_r);
      default:        cfg_prdata = '0;
    endcase
  end

  spi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spi_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_tuser),
    .note_number    (in_tdata[6:0]),
    .velocity       (in_tdata[13:7]),
    .table_address  (in_tdata[29:14]),
    .table_value    (in_tdata[45:30]),
    .sample_length  (sample_length_r),
    .recording_rate (recording_rate_r),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_sample     (out_tdata),
    .out_playing    (out_tuser)
  );

`ifndef SYNTH
  // Only a tick transaction ever produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != MODE_TICK)) |=> !$rose(out_tvalid))
    else $error("result produced by a non-tick transaction");

  // A tick occupies the block, so no second transaction is taken at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == MODE_TICK)) |=> !in_tready)
    else $error("transaction accepted while a tick is in progress");

  // A silent result carries a zero sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("silent result with non-zero sample");
`endif

endmodule
